// File: rtl/core/ipv4mc_pkg.sv
// shared types and constants of the ipv4 address and netmask classifier
`timescale 1ns / 1ps

package ipv4mc_pkg;

  // token class codes
  localparam logic [2:0] CLS_A     = 3'd0;
  localparam logic [2:0] CLS_B     = 3'd1;
  localparam logic [2:0] CLS_C     = 3'd2;
  localparam logic [2:0] CLS_D     = 3'd3;
  localparam logic [2:0] CLS_E     = 3'd4;
  localparam logic [2:0] CLS_ERROR = 3'd5;
  localparam logic [2:0] CLS_OTHER = 3'd6;

  // counter slots: one per class a..e and error, then private
  localparam int NUM_COUNTERS = 7;
  localparam int IDX_PRIV     = 6;

  // token end queue between parser and counter stage (power of two depth)
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  // one queue word: the finished token's class and private flag
  typedef struct packed {
    logic [2:0] line_class;
    logic       is_private;
  } evt_t;

endpackage

// File: rtl/core/ipv4mc_front.sv
// byte parser: splits tokens, reads address and mask fields, classifies each token
`timescale 1ns / 1ps

module ipv4mc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ch,
  input  logic               end_of_stream,
  input  logic               q_space,
  output logic               q_push,
  output ipv4mc_pkg::evt_t   q_data
);

  // section codes
  localparam logic [1:0] SEC_ADDR = 2'd0;
  localparam logic [1:0] SEC_MASK = 2'd1;
  localparam logic [1:0] SEC_SKIP = 2'd2;
  localparam logic [1:0] SEC_FAIL = 2'd3;

  // text bytes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // first octet ranges and private prefixes
  localparam logic [7:0] A_LO     = 8'd1;
  localparam logic [7:0] A_HI     = 8'd126;
  localparam logic [7:0] B_LO     = 8'd128;
  localparam logic [7:0] B_HI     = 8'd191;
  localparam logic [7:0] C_LO     = 8'd192;
  localparam logic [7:0] C_HI     = 8'd223;
  localparam logic [7:0] D_LO     = 8'd224;
  localparam logic [7:0] E_LO     = 8'd240;
  localparam logic [7:0] PRIV_A   = 8'd10;
  localparam logic [7:0] PRIV_B   = 8'd172;
  localparam logic [7:0] PRIV_B_LO = 8'd16;
  localparam logic [7:0] PRIV_B_HI = 8'd31;
  localparam logic [7:0] PRIV_C   = 8'd192;
  localparam logic [7:0] PRIV_C2  = 8'd168;

  localparam logic [7:0] OCT_ONES = 8'hFF;
  localparam logic [8:0] FIELD_SAT = 9'd256;

  typedef struct packed {
    logic            in_token;
    logic [1:0]      section;
    logic [2:0]      fa;
    logic            stopped;
    logic [8:0]      fval;
    logic            fneg;
    logic            fend;
    logic            fhas;
    logic [1:0][7:0] addr;
    logic [3:0][7:0] mask;
  } pst_t;

  // close the current field: accept it or stop the section
  function automatic pst_t close_fld(pst_t s);
    pst_t       r;
    logic       ok;
    logic [7:0] v;
    logic [7:0] inv;
    r   = s;
    v   = s.fval[7:0];
    inv = ~v;
    ok  = s.fhas && !(s.fneg && (s.fval != 9'd0)) && (s.fval <= 9'd255);
    if ((s.section == SEC_MASK) && ((inv & (inv + 8'd1)) != 8'd0)) ok = 1'b0;
    if (!s.stopped && (s.section <= SEC_MASK)) begin
      if (!ok) begin
        r.stopped = 1'b1;
      end else begin
        if (s.section == SEC_ADDR) begin
          if (s.fa < 3'd2) r.addr[s.fa[0]] = v;
        end else if (s.fa < 3'd4) begin
          r.mask[s.fa[1:0]] = v;
        end
        if (s.fa < 3'd5) r.fa = s.fa + 3'd1;
      end
    end
    r.fval = '0;
    r.fneg = 1'b0;
    r.fend = 1'b0;
    r.fhas = 1'b0;
    return r;
  endfunction

  // four octets, ones then zeros, not all ones
  function automatic logic mask_ok(pst_t s);
    logic ok;
    ok = (s.fa == 3'd4) && (s.mask[3] != OCT_ONES);
    for (int i = 1; i < 4; i++) begin
      if ((s.mask[i] != 8'd0) && (s.mask[i-1] != OCT_ONES)) ok = 1'b0;
    end
    return ok;
  endfunction

  // tilde: close the section and move on
  function automatic pst_t end_sec(pst_t s);
    pst_t r;
    r = close_fld(s);
    if (s.section == SEC_ADDR) begin
      r.section = (r.fa == 3'd4) ? SEC_MASK : SEC_FAIL;
    end else if (s.section == SEC_MASK) begin
      r.section = mask_ok(r) ? SEC_SKIP : SEC_FAIL;
    end
    r.fa      = '0;
    r.stopped = 1'b0;
    return r;
  endfunction

  // one field byte, atoi style
  function automatic pst_t feed(pst_t s, logic [7:0] c);
    pst_t        r;
    logic [11:0] acc;
    r   = s;
    acc = 12'(s.fval) * 12'd10 + 12'(c - CH_ZERO);
    if (!s.fend) begin
      if (!s.fhas && ((c == CH_PLUS) || (c == CH_MINUS))) begin
        r.fneg = (c == CH_MINUS);
      end else if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
        r.fval = (acc > 12'(FIELD_SAT)) ? FIELD_SAT : acc[8:0];
      end else begin
        r.fend = 1'b1;
      end
      r.fhas = 1'b1;
    end
    return r;
  endfunction

  pst_t       st;
  pst_t       st_next;
  pst_t       s1;
  pst_t       s2;
  logic       sep;
  logic       emit;
  logic       accept;
  logic       valid_tok;
  logic [7:0] a0;
  logic [7:0] a1;
  logic [2:0] cls;
  logic       priv;

  assign in_ready = q_space;
  assign accept   = in_valid && in_ready;

  // byte step and token end classification
  always_comb begin
    sep = ((ch >= CH_TAB) && (ch <= CH_CR)) || (ch == CH_SPACE);
    s1  = st;
    if (!sep) begin
      if (st.section <= SEC_MASK) begin
        if (ch == CH_TILDE) begin
          s1 = end_sec(st);
        end else if (ch == CH_DOT) begin
          s1 = close_fld(st);
        end else if (!st.stopped) begin
          s1 = feed(st, ch);
        end
      end
      s1.in_token = 1'b1;
    end
    emit = sep ? st.in_token : end_of_stream;

    s2 = close_fld(s1);
    valid_tok = (s2.section == SEC_SKIP) || ((s2.section == SEC_MASK) && mask_ok(s2));
    a0   = s2.addr[0];
    a1   = s2.addr[1];
    priv = 1'b0;
    if (!valid_tok) begin
      cls = ipv4mc_pkg::CLS_ERROR;
    end else if ((a0 >= A_LO) && (a0 <= A_HI)) begin
      cls  = ipv4mc_pkg::CLS_A;
      priv = (a0 == PRIV_A);
    end else if ((a0 >= B_LO) && (a0 <= B_HI)) begin
      cls  = ipv4mc_pkg::CLS_B;
      priv = (a0 == PRIV_B) && (a1 >= PRIV_B_LO) && (a1 <= PRIV_B_HI);
    end else if ((a0 >= C_LO) && (a0 <= C_HI)) begin
      cls  = ipv4mc_pkg::CLS_C;
      priv = (a0 == PRIV_C) && (a1 == PRIV_C2);
    end else if ((a0 >= D_LO) && (a0 < E_LO)) begin
      cls = ipv4mc_pkg::CLS_D;
    end else if (a0 >= E_LO) begin
      cls = ipv4mc_pkg::CLS_E;
    end else begin
      cls = ipv4mc_pkg::CLS_OTHER;
    end

    st_next = st;
    if (accept) st_next = emit ? pst_t'('0) : s1;
  end

  assign q_push             = accept && emit;
  assign q_data.line_class  = cls;
  assign q_data.is_private  = priv;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/core/ipv4mc_fifo.sv
// short queue of token end words between parser and counter stage
`timescale 1ns / 1ps

module ipv4mc_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ipv4mc_pkg::evt_t push_data,
  output logic             space,
  output logic             pop_valid,
  input  logic             pop,
  output ipv4mc_pkg::evt_t pop_data
);

  ipv4mc_pkg::evt_t                  slots [ipv4mc_pkg::QUEUE_DEPTH];
  logic [ipv4mc_pkg::PTR_W-1:0]      wr_ptr;
  logic [ipv4mc_pkg::PTR_W-1:0]      rd_ptr;
  logic [ipv4mc_pkg::LEVEL_W-1:0]    level;
  logic                              do_push;
  logic                              do_pop;

  assign space     = (level != ipv4mc_pkg::LEVEL_W'(ipv4mc_pkg::QUEUE_DEPTH));
  assign pop_valid = (level != '0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && space;
  assign do_pop    = pop && pop_valid;

  // word storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + ipv4mc_pkg::PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + ipv4mc_pkg::PTR_W'(1);
      if (do_push && !do_pop) begin
        level <= level + ipv4mc_pkg::LEVEL_W'(1);
      end else if (!do_push && do_pop) begin
        level <= level - ipv4mc_pkg::LEVEL_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/ipv4mc_back.sv
// counter stage: bumps the saturating counters and holds the output word
`timescale 1ns / 1ps

module ipv4mc_back #(
  parameter int COUNT_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  ipv4mc_pkg::evt_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       line_class,
  output logic             is_private,
  output logic [31:0]      count_a,
  output logic [31:0]      count_b,
  output logic [31:0]      count_c,
  output logic [31:0]      count_d,
  output logic [31:0]      count_e,
  output logic [31:0]      count_error,
  output logic [31:0]      count_private
);

  localparam int OUT_W = (COUNT_BITS < 32) ? COUNT_BITS : 32;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] cnt      [ipv4mc_pkg::NUM_COUNTERS];
  logic [COUNT_BITS-1:0] cnt_next [ipv4mc_pkg::NUM_COUNTERS];

  // take a word when the output register is free or being emptied
  assign q_pop = q_valid && (!out_valid || out_ready);

  // saturating bumps for class and private
  always_comb begin
    for (int k = 0; k < ipv4mc_pkg::NUM_COUNTERS; k++) begin
      cnt_next[k] = cnt[k];
      if (k == ipv4mc_pkg::IDX_PRIV) begin
        if (q_data.is_private && (cnt[k] != CNT_MAX)) cnt_next[k] = cnt[k] + 1'b1;
      end else if ((q_data.line_class == 3'(k)) && (cnt[k] != CNT_MAX)) begin
        cnt_next[k] = cnt[k] + 1'b1;
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ipv4mc_pkg::NUM_COUNTERS; k++) cnt[k] <= '0;
    end else if (q_pop) begin
      cnt <= cnt_next;
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_class <= q_data.line_class;
      is_private <= q_data.is_private;
    end
  end

  // counters only move when a new word is loaded, so they read out directly
  assign count_a       = 32'(cnt[ipv4mc_pkg::CLS_A][OUT_W-1:0]);
  assign count_b       = 32'(cnt[ipv4mc_pkg::CLS_B][OUT_W-1:0]);
  assign count_c       = 32'(cnt[ipv4mc_pkg::CLS_C][OUT_W-1:0]);
  assign count_d       = 32'(cnt[ipv4mc_pkg::CLS_D][OUT_W-1:0]);
  assign count_e       = 32'(cnt[ipv4mc_pkg::CLS_E][OUT_W-1:0]);
  assign count_error   = 32'(cnt[ipv4mc_pkg::CLS_ERROR][OUT_W-1:0]);
  assign count_private = 32'(cnt[ipv4mc_pkg::IDX_PRIV][OUT_W-1:0]);

endmodule

// File: rtl/core/ipv4_mask_text_classifier.sv
// top level of the ipv4 address and netmask text classifier
//
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | ch, end_of_stream
//  output  | out_valid / out_ready| line_class, is_private, seven count words
//
// one byte per cycle while the queue has space; a byte is parsed in the cycle it is taken
// a token end word is written into the queue when its closing byte is taken, then loaded into the output register
// the parser stalls only when the two word queue is full
// rst (synchronous) clears parser state, queue and all counters
`timescale 1ns / 1ps

module ipv4_mask_text_classifier #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  line_class,
  output logic        is_private,
  output logic [31:0] count_a,
  output logic [31:0] count_b,
  output logic [31:0] count_c,
  output logic [31:0] count_d,
  output logic [31:0] count_e,
  output logic [31:0] count_error,
  output logic [31:0] count_private
);

  logic             q_space;
  logic             q_push;
  ipv4mc_pkg::evt_t q_in;
  logic             q_valid;
  logic             q_pop;
  ipv4mc_pkg::evt_t q_out;

  // parser
  ipv4mc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ch            (ch),
    .end_of_stream (end_of_stream),
    .q_space       (q_space),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  // token end queue
  ipv4mc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .space     (q_space),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  // counters and output word
  ipv4mc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .line_class    (line_class),
    .is_private    (is_private),
    .count_a       (count_a),
    .count_b       (count_b),
    .count_c       (count_c),
    .count_d       (count_d),
    .count_e       (count_e),
    .count_error   (count_error),
    .count_private (count_private)
  );

`ifndef SYNTH
  // a token end word is never pushed into a full queue
  a_push_space: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_space)
    else $error("token end word pushed into full queue");

  // only class a, b or c can be private
  a_priv_class: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_private) |-> (line_class == ipv4mc_pkg::CLS_A ||
      line_class == ipv4mc_pkg::CLS_B || line_class == ipv4mc_pkg::CLS_C))
    else $error("private word with a class other than a, b or c");

  // a private word always follows at least one private count
  a_priv_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_private) |-> (count_private != 32'd0))
    else $error("private word with zero private count");

  // nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid after reset");
`endif

endmodule
